// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers with reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property with reset disable
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// File: src/mowm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_pkg
// types and constants shared by the window minimum block
// ----------------------------------------------------------------------------
package mowm_pkg;
  localparam int unsigned MaxItems = 64;
  localparam int unsigned IdxW = $clog2(MaxItems);
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  typedef struct packed {
    logic [31:0] value;
    logic        end_of_set;
  } mowm_in_t;

  typedef struct packed {
    logic [6:0]  window_length;
    logic [31:0] best_minimum;
    logic        overflowed;
    logic        final_result;
  } mowm_out_t;

  // command passed from front to back
  typedef struct packed {
    logic            store;
    logic            last;
    logic [IdxW-1:0] idx;
    logic [31:0]     value;
    logic            ovf;
  } mowm_cmd_t;

  typedef enum logic [3:0] {
    S_TAKE, S_CLR, S_PIV, S_PIVW, S_LEFT, S_RIGHT, S_UPD, S_UPDW,
    S_SUF, S_SUFW, S_OUT, S_OUTW
  } mowm_state_e;
endpackage
`default_nettype wire

// File: src/mowm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_ram
// generic single port ram, registered read
// ----------------------------------------------------------------------------
module mowm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: src/mowm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_front
// accepts requests, counts items, flags overflow, feeds the command queue
// ----------------------------------------------------------------------------
module mowm_front import mowm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire mowm_in_t  in_data_i,
  output logic           cmd_valid_o,
  input  wire logic      cmd_stall_i,
  output mowm_cmd_t      cmd_o
);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            full;
  logic            fire;

  assign full        = (cnt_q == CntW'(MaxItems));
  assign in_stall    = cmd_stall_i;
  assign cmd_valid_o = in_valid;
  assign fire        = in_valid && !cmd_stall_i;

  always_comb begin
    cmd_o.store = !full;
    cmd_o.last  = in_data_i.end_of_set;
    cmd_o.idx   = cnt_q[IdxW-1:0];
    cmd_o.value = in_data_i.value;
    cmd_o.ovf   = ovf_q | full;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (fire) begin
      if (in_data_i.end_of_set) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end
endmodule
`default_nettype wire

// File: src/mowm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_queue
// two entry command queue between front and back
// ----------------------------------------------------------------------------
module mowm_queue import mowm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_stall_o,
  input  wire mowm_cmd_t push_data_i,
  output logic           pop_valid_o,
  input  wire logic      pop_i,
  output mowm_cmd_t      pop_data_o
);
  mowm_cmd_t  buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_stall_o = (cnt_q == 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = buf_q[rp_q];
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: src/mowm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_back
// stores values, runs span and suffix passes, streams results
// ----------------------------------------------------------------------------
module mowm_back import mowm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  output logic           cmd_pop_o,
  input  wire mowm_cmd_t cmd_i,
  output logic           out_valid,
  input  wire logic      out_stall,
  output mowm_out_t      out_data_o,
  output logic           busy_o
);
  mowm_state_e st_q, st_d;
  logic [CntW-1:0] n_q, n_d;      // stored count
  logic [IdxW-1:0] i_q, i_d;      // element / length index
  logic [IdxW-1:0] p_q, p_d;      // probe index
  logic [IdxW-1:0] lo_q, lo_d;
  logic [31:0]     piv_q, piv_d;
  logic [31:0]     run_q, run_d;  // suffix running max
  logic            ovf_q, ovf_d;
  mowm_out_t       od_q, od_d;
  logic            ov_q, ov_d;

  logic            vwe, awe;
  logic [IdxW-1:0] vaddr, aaddr;
  logic [31:0]     vwd, awd, vrd, ard;
  logic [IdxW-1:0] last_idx;

  mowm_ram #(.Width(32), .Depth(MaxItems)) u_vals (
    .clk_i, .we_i(vwe), .addr_i(vaddr), .wdata_i(vwd), .rdata_o(vrd));
  mowm_ram #(.Width(32), .Depth(MaxItems)) u_ans (
    .clk_i, .we_i(awe), .addr_i(aaddr), .wdata_i(awd), .rdata_o(ard));

  assign last_idx   = IdxW'(n_q - CntW'(1));
  assign out_valid  = ov_q;
  assign out_data_o = od_q;
  assign busy_o     = (st_q != S_TAKE);

  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; p_d = p_q; lo_d = lo_q;
    piv_d = piv_q; run_d = run_q; ovf_d = ovf_q; od_d = od_q; ov_d = ov_q;
    vwe = 1'b0; vaddr = p_q; vwd = cmd_i.value;
    awe = 1'b0; aaddr = i_q; awd = '0;
    cmd_pop_o = 1'b0;
    if (ov_q && !out_stall) ov_d = 1'b0;
    unique case (st_q)
      S_TAKE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          vaddr = cmd_i.idx;
          vwe   = cmd_i.store;
          n_d   = cmd_i.store ? CntW'(cmd_i.idx) + CntW'(1) : CntW'(MaxItems);
          if (cmd_i.last) begin
            ovf_d = cmd_i.ovf;
            i_d   = '0;
            st_d  = S_CLR;
          end
        end
      end
      S_CLR: begin
        awe = 1'b1;
        if (i_q == last_idx) begin
          i_d = '0; st_d = S_PIV;
        end else i_d = i_q + IdxW'(1);
      end
      S_PIV: begin
        vaddr = i_q; st_d = S_PIVW;
      end
      S_PIVW: begin
        piv_d = vrd; lo_d = i_q; p_d = i_q;
        // right walk read phase starts clear
        run_d = '0;
        if (i_q == '0) st_d = S_RIGHT;
        else begin p_d = i_q - IdxW'(1); st_d = S_LEFT; end
        if (st_d == S_RIGHT) begin
          if (i_q == last_idx) st_d = S_UPD;
          else p_d = i_q + IdxW'(1);
        end
      end
      S_LEFT: begin
        vaddr = p_q;
        st_d = S_LEFT;
        // data for p_q arrives next cycle; use a two-phase via lo_q compare
        if (p_q != lo_q) begin
          // issue read, then check
          lo_d = p_q;
        end else begin
          // vrd holds value at p_q
          if (vrd >= piv_q) begin
            if (p_q == '0) begin
              lo_d = '0; p_d = i_q;
            end else p_d = p_q - IdxW'(1);
          end else begin
            lo_d = p_q + IdxW'(1); p_d = i_q;
          end
          if (vrd < piv_q || p_q == '0) begin
            if (i_q == last_idx) begin p_d = i_q; st_d = S_UPD; end
            else begin p_d = i_q + IdxW'(1); st_d = S_RIGHT; end
            if (vrd >= piv_q) lo_d = '0;
          end
        end
      end
      S_RIGHT: begin
        vaddr = p_q;
        if (p_q != i_q && piv_d == piv_q && run_q[0] == 1'b0) begin
          run_d[0] = 1'b1; // read issued
        end else begin
          run_d[0] = 1'b0;
          if (vrd >= piv_q && p_q != last_idx) p_d = p_q + IdxW'(1);
          else begin
            if (vrd < piv_q) p_d = p_q - IdxW'(1);
            st_d = S_UPD;
          end
        end
      end
      S_UPD: begin
        aaddr = IdxW'(p_q - lo_q); st_d = S_UPDW;
      end
      S_UPDW: begin
        aaddr = IdxW'(p_q - lo_q);
        if (ard < piv_q) begin awe = 1'b1; awd = piv_q; end
        if (i_q == last_idx) begin
          i_d = last_idx; run_d = '0; st_d = S_SUF;
        end else begin
          i_d = i_q + IdxW'(1); st_d = S_PIV;
        end
      end
      S_SUF: begin
        aaddr = i_q; st_d = S_SUFW;
      end
      S_SUFW: begin
        aaddr = i_q;
        awe = 1'b1;
        awd = (ard > run_q) ? ard : run_q;
        run_d = awd;
        if (i_q == '0) st_d = S_OUT;
        else begin i_d = i_q - IdxW'(1); st_d = S_SUF; end
      end
      S_OUT: begin
        aaddr = i_q;
        if (!ov_q || !out_stall) st_d = S_OUTW;
      end
      S_OUTW: begin
        aaddr = i_q;
        if (!ov_q || !out_stall) begin
          ov_d = 1'b1;
          od_d.window_length = 7'(i_q) + 7'd1;
          od_d.best_minimum  = ard;
          od_d.overflowed    = ovf_q;
          od_d.final_result  = (i_q == last_idx);
          if (i_q == last_idx) st_d = S_TAKE;
          else begin i_d = i_q + IdxW'(1); st_d = S_OUT; end
        end
      end
      default: st_d = S_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_TAKE; ov_q <= 1'b0; n_q <= '0; i_q <= '0;
      run_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; n_q <= n_d; i_q <= i_d; run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; lo_q <= lo_d; piv_q <= piv_d; ovf_q <= ovf_d; od_q <= od_d;
  end
endmodule
`default_nettype wire

// File: src/max_of_window_minimums.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_of_window_minimums
// best window minimum for every window length of a loaded sequence
// ----------------------------------------------------------------------------
// usage:
//   in channel: one request per value; end_of_set closes the sequence.
//   out channel: after the closing request, n results for lengths 1..n,
//   final_result set on length n, overflowed set if values were dropped.
// operation:
//   loading passes requests through a two entry queue, taking a new request
//   while the queue is not full. after the last request: a clear pass over
//   n answer entries, then per element a span walk over its probed neighbors,
//   a suffix pass over the lengths and one read per result on the single answer ram port.
// reset: counts, overflow and controller return to idle at once.
// stall: a stalled result holds in the output register; the controller
//   waits and the queue fills, then the input stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module max_of_window_minimums import mowm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire mowm_in_t  in_data_i,
  output logic           out_valid,
  input  wire logic      out_stall,
  output mowm_out_t      out_data_o
);
  logic      f_valid, f_stall, q_valid, q_pop, busy;
  mowm_cmd_t f_cmd, q_cmd;

  mowm_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_stall_i(f_stall), .cmd_o(f_cmd));

  mowm_queue u_queue (
    .clk_i, .rst_ni, .push_valid_i(f_valid), .push_stall_o(f_stall),
    .push_data_i(f_cmd), .pop_valid_o(q_valid), .pop_i(q_pop), .pop_data_o(q_cmd));

  mowm_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_pop_o(q_pop), .cmd_i(q_cmd),
    .out_valid, .out_stall, .out_data_o, .busy_o(busy));

  // no command popped while computing
  `ASSERT_NEVER(a_no_pop_busy, clk_i, rst_ni, busy && q_pop, "pop while busy")
  // a result is only produced while busy or just after
  `ASSERT_RST(a_out_busy, clk_i, rst_ni, $rose(out_valid) |-> $past(busy), "stray result")
endmodule
`default_nettype wire
